// ----- hdl/adcms_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ADC measurement sequencer package
// Shared widths, codes, state types and payload structs of the sequencer.
// ============================================================================
package adcms_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W   = 10;
    localparam int COEF_W     = 16;
    localparam int WIN_W      = 16;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 22;
    localparam int VAL_W      = 26;
    localparam int CHAN_W     = 2;
    localparam int PROD_W     = SUM_W + COEF_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_SLOTS  = 4;

    // Saturation limits.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [WIN_W-1:0] MS_MAX  = {WIN_W{1'b1}};

    // Default number of temperature samples per average.
    localparam int TEMP_SAMPLES_DEF = 3;

    // Depth of the job queue between front and back.
    localparam int JOBQ_DEPTH = 2;

    // Register reset values.
    localparam logic [SAMPLE_W-1:0] SPLIT_THRESHOLD_RST = 10'd512;
    localparam logic [COEF_W-1:0]   COEF_RST            = 16'd4096;
    localparam logic [WIN_W-1:0]    WINDOW_MS_RST       = 16'd100;

    // Input action codes.
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPLIT_THRESHOLD = 3'd0,
        CFG_VOLTAGE_COEF    = 3'd1,
        CFG_CURRENT_COEF    = 3'd2,
        CFG_TEMP_COEF       = 3'd3,
        CFG_WINDOW_MS       = 3'd4
    } cfg_index_t;

    // Measurement phases.
    typedef enum logic [1:0] {
        PH_VOLT = 2'd0,
        PH_CURR = 2'd1,
        PH_TEMP = 2'd2
    } phase_t;

    // Work handed from the front to the back.
    typedef enum logic [1:0] {
        JOB_PLAIN = 2'd0,
        JOB_VOLT  = 2'd1,
        JOB_CURR  = 2'd2,
        JOB_TEMP  = 2'd3
    } job_kind_t;

    // Result slots, in output order.
    typedef enum logic [1:0] {
        SLOT_BATT = 2'd0,
        SLOT_SIG  = 2'd1,
        SLOT_CURR = 2'd2,
        SLOT_TEMP = 2'd3
    } slot_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE  = 3'd0,
        BK_MUL   = 3'd1,
        BK_DGO   = 3'd2,
        BK_DWAIT = 3'd3,
        BK_TMUL  = 3'd4,
        BK_NEXT  = 3'd5,
        BK_OUT   = 3'd6
    } back_state_t;

    // Input word.
    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] adc_sample;
    } in_item_t;

    // Result word.
    typedef struct packed {
        logic [CHAN_W-1:0] next_channel;
        logic [VAL_W-1:0]  battery_voltage;
        logic              battery_voltage_new;
        logic [VAL_W-1:0]  signal_voltage;
        logic              signal_voltage_new;
        logic [VAL_W-1:0]  charge_current;
        logic              charge_current_new;
        logic [VAL_W-1:0]  temperature_value;
        logic              temperature_new;
    } out_item_t;

    // Configuration register file.
    typedef struct packed {
        logic [SAMPLE_W-1:0] split_threshold;
        logic [COEF_W-1:0]   voltage_coef;
        logic [COEF_W-1:0]   current_coef;
        logic [COEF_W-1:0]   temp_coef;
        logic [WIN_W-1:0]    window_ms;
    } cfg_t;

    // One queued job with a snapshot of the accumulators.
    typedef struct packed {
        job_kind_t         kind;
        logic [CHAN_W-1:0] next_channel;
        logic [SUM_W-1:0]  sum_a;
        logic [CNT_W-1:0]  count_a;
        logic [SUM_W-1:0]  sum_b;
        logic [CNT_W-1:0]  count_b;
    } job_t;

    // Job queue status.
    typedef struct packed {
        logic full;
        logic empty;
    } jobq_stat_t;

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [CNT_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [VAL_W-1:0] quo;
    } div_rsp_t;

endpackage

// ----- hdl/adcms_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ADC measurement sequencer front end
// Tracks phase, elapsed time and accumulators, and classifies each word
// into a job for the back end.
// ============================================================================
module adcms_front #(
    parameter int TEMP_SAMPLES = adcms_pkg::TEMP_SAMPLES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  adcms_pkg::in_item_t s_data,
    input  adcms_pkg::cfg_t    cfg,
    output adcms_pkg::job_t    job
);
    import adcms_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [WIN_W-1:0]   elapsed_reg, elapsed_next;
    logic [SUM_W-1:0]   sum_a_reg, sum_a_next, sum_b_reg, sum_b_next;
    logic [CNT_W-1:0]   count_a_reg, count_a_next, count_b_reg, count_b_next;
    job_kind_t          kind;
    logic               is_sample;
    logic               window_open;
    logic               room_a, room_b;
    logic [SUM_W-1:0]   add_a, add_b;
    logic [SUM_W-1:0]   sample_ext;

    // Decoded conditions of the current word.
    assign is_sample   = (s_data.action == ACT_SAMPLE);
    assign window_open = (elapsed_reg < cfg.window_ms);
    assign room_a      = (count_a_reg != CNT_MAX);
    assign room_b      = (count_b_reg != CNT_MAX);
    assign sample_ext  = SUM_W'(s_data.adc_sample);
    assign add_a       = sum_a_reg + sample_ext;
    assign add_b       = sum_b_reg + sample_ext;

    // Phase sequencing and accumulation.
    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        sum_a_next   = sum_a_reg;
        count_a_next = count_a_reg;
        sum_b_next   = sum_b_reg;
        count_b_next = count_b_reg;
        kind         = JOB_PLAIN;
        if (!is_sample) begin
            if (elapsed_reg != MS_MAX) begin
                elapsed_next = elapsed_reg + 1'b1;
            end
        end else begin
            unique case (phase_reg)
                PH_CURR: begin
                    if (window_open) begin
                        if (room_a) begin
                            sum_a_next   = add_a;
                            count_a_next = count_a_reg + 1'b1;
                        end
                    end else begin
                        kind         = JOB_CURR;
                        sum_a_next   = '0;
                        count_a_next = '0;
                        sum_b_next   = '0;
                        count_b_next = '0;
                        phase_next   = PH_TEMP;
                    end
                end
                PH_TEMP: begin
                    if (count_a_reg < CNT_W'(TEMP_SAMPLES)) begin
                        if (room_a) begin
                            sum_a_next   = add_a;
                            count_a_next = count_a_reg + 1'b1;
                        end
                    end else begin
                        kind         = JOB_TEMP;
                        sum_a_next   = '0;
                        count_a_next = '0;
                        sum_b_next   = '0;
                        count_b_next = '0;
                        phase_next   = PH_VOLT;
                        elapsed_next = '0;
                    end
                end
                default: begin
                    // Voltage phase; an unused phase code behaves the same.
                    if (window_open) begin
                        if (s_data.adc_sample < cfg.split_threshold) begin
                            if (room_a) begin
                                sum_a_next   = add_a;
                                count_a_next = count_a_reg + 1'b1;
                            end
                        end else if (room_b) begin
                            sum_b_next   = add_b;
                            count_b_next = count_b_reg + 1'b1;
                        end
                    end else begin
                        kind         = JOB_VOLT;
                        sum_a_next   = '0;
                        count_a_next = '0;
                        sum_b_next   = '0;
                        count_b_next = '0;
                        phase_next   = PH_CURR;
                        elapsed_next = '0;
                    end
                end
            endcase
        end
    end

    // Job word carries the accumulators as they stood before this word.
    always_comb begin
        job.kind         = kind;
        job.next_channel = CHAN_W'(phase_next) + CHAN_W'(1);
        job.sum_a        = sum_a_reg;
        job.count_a      = count_a_reg;
        job.sum_b        = sum_b_reg;
        job.count_b      = count_b_reg;
    end

    // State registers advance on every accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_VOLT;
            elapsed_reg <= '0;
            sum_a_reg   <= '0;
            count_a_reg <= '0;
            sum_b_reg   <= '0;
            count_b_reg <= '0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            sum_a_reg   <= sum_a_next;
            count_a_reg <= count_a_next;
            sum_b_reg   <= sum_b_next;
            count_b_reg <= count_b_next;
        end
    end

endmodule

// ----- hdl/adcms_jobq.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ADC measurement sequencer job queue
// Short FIFO that decouples the front end from the back end.
// ============================================================================
module adcms_jobq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  adcms_pkg::job_t       wr_data,
    input  logic                  pop,
    output adcms_pkg::job_t       rd_data,
    output adcms_pkg::jobq_stat_t stat
);
    import adcms_pkg::*;

    localparam int PTR_W   = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam int COUNT_W = $clog2(JOBQ_DEPTH + 1);

    job_t               mem_reg [JOBQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    // Status and guarded handshakes.
    assign stat.full  = (count_reg == COUNT_W'(JOBQ_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // The fill count never exceeds the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(JOBQ_DEPTH))
        else $error("job queue count exceeds depth");

    // A pop without a push lowers the fill count by one.
    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop && !do_push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("job queue pop did not lower the count");

endmodule

// ----- hdl/adcms_div.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ADC measurement sequencer divider
// Restoring divider that produces one quotient bit per cycle. The caller
// guarantees that the quotient fits the result width.
// ============================================================================
module adcms_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  adcms_pkg::div_req_t req,
    output adcms_pkg::div_rsp_t rsp
);
    import adcms_pkg::*;

    localparam int STEP_W = $clog2(VAL_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [VAL_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    // One trial subtraction per cycle.
    assign trial = {rem_reg, quo_reg[VAL_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    // Control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(VAL_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            rem_reg <= req.num[PROD_W-1:VAL_W];
            quo_reg <= req.num[VAL_W-1:0];
            den_reg <= req.den;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_reg <= {quo_reg[VAL_W-2:0], fits};
        end
    end

    // A finished division always follows a busy cycle.
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

// ----- hdl/adcms_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ADC measurement sequencer back end
// Pops jobs, computes scaled averages with a shared multiplier and the
// divider, keeps the result registers and drives the output register.
// ============================================================================
module adcms_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  adcms_pkg::job_t       q_data,
    input  adcms_pkg::jobq_stat_t q_stat,
    output logic                  q_pop,
    input  adcms_pkg::cfg_t       cfg,
    output adcms_pkg::div_req_t   div_req,
    input  adcms_pkg::div_rsp_t   div_rsp,
    output logic                  m_valid,
    input  logic                  m_ready,
    output adcms_pkg::out_item_t  m_data
);
    import adcms_pkg::*;

    back_state_t            state_reg, state_next;
    job_t                   job_reg;
    slot_t                  slot_reg;
    slot_t                  first_slot;
    logic [PROD_W-1:0]      prod_reg;
    logic [VAL_W-1:0]       result_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   new_reg;
    logic                   m_valid_reg;
    out_item_t              m_data_reg;
    out_item_t              m_data_next;

    logic [SUM_W-1:0]       cur_sum;
    logic [CNT_W-1:0]       cur_cnt;
    logic [COEF_W-1:0]      cur_coef;
    logic [SUM_W-1:0]       mul_a;
    logic [COEF_W-1:0]      mul_b;
    logic [PROD_W-1:0]      mul_prod;
    logic                   out_free;
    logic                   out_load;
    logic                   div_start;

    assign out_free = !m_valid_reg || m_ready;

    // Operand selection for the slot being computed.
    always_comb begin
        cur_sum  = job_reg.sum_a;
        cur_cnt  = job_reg.count_a;
        cur_coef = cfg.voltage_coef;
        case (slot_reg)
            SLOT_SIG: begin
                cur_sum = job_reg.sum_b;
                cur_cnt = job_reg.count_b;
            end
            SLOT_CURR: cur_coef = cfg.current_coef;
            SLOT_TEMP: cur_coef = COEF_W'(1);
            default: ;
        endcase
    end

    // Shared multiplier: sum times coefficient, or quotient times the
    // temperature coefficient.
    assign mul_a    = (state_reg == BK_TMUL) ? SUM_W'(div_rsp.quo) : cur_sum;
    assign mul_b    = (state_reg == BK_TMUL) ? cfg.temp_coef : cur_coef;
    assign mul_prod = mul_a * mul_b;

    // First slot of each job kind.
    always_comb begin
        unique case (q_data.kind)
            JOB_CURR: first_slot = SLOT_CURR;
            JOB_TEMP: first_slot = SLOT_TEMP;
            default:  first_slot = SLOT_BATT;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = (q_data.kind == JOB_PLAIN) ? BK_OUT : BK_MUL;
                end
            end
            BK_MUL:   state_next = (cur_cnt != '0) ? BK_DGO : BK_NEXT;
            BK_DGO:   state_next = BK_DWAIT;
            BK_DWAIT: begin
                if (div_rsp.done) begin
                    state_next = (slot_reg == SLOT_TEMP) ? BK_TMUL : BK_NEXT;
                end
            end
            BK_TMUL:  state_next = BK_NEXT;
            BK_NEXT:  state_next = (slot_reg == SLOT_BATT) ? BK_MUL : BK_OUT;
            BK_OUT: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            BK_IDLE: q_pop     = !q_stat.empty;
            BK_DGO:  div_start = 1'b1;
            BK_OUT:  out_load  = out_free;
            default: ;
        endcase
    end

    assign div_req.start = div_start;
    assign div_req.num   = prod_reg;
    assign div_req.den   = cur_cnt;

    // Result word assembled from the result registers.
    always_comb begin
        m_data_next.next_channel        = job_reg.next_channel;
        m_data_next.battery_voltage     = result_reg[SLOT_BATT];
        m_data_next.battery_voltage_new = new_reg[SLOT_BATT];
        m_data_next.signal_voltage      = result_reg[SLOT_SIG];
        m_data_next.signal_voltage_new  = new_reg[SLOT_SIG];
        m_data_next.charge_current      = result_reg[SLOT_CURR];
        m_data_next.charge_current_new  = new_reg[SLOT_CURR];
        m_data_next.temperature_value   = result_reg[SLOT_TEMP];
        m_data_next.temperature_new     = new_reg[SLOT_TEMP];
    end

    // Control, result registers and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            slot_reg    <= SLOT_BATT;
            new_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                result_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                slot_reg <= first_slot;
                new_reg  <= '0;
            end
            if (state_reg == BK_NEXT && slot_reg == SLOT_BATT) begin
                slot_reg <= SLOT_SIG;
            end
            if (state_reg == BK_DWAIT && div_rsp.done && slot_reg != SLOT_TEMP) begin
                result_reg[slot_reg] <= div_rsp.quo;
                new_reg[slot_reg]    <= 1'b1;
            end
            if (state_reg == BK_TMUL) begin
                result_reg[SLOT_TEMP] <= mul_prod[VAL_W-1:0];
                new_reg[SLOT_TEMP]    <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_data;
        end
        if (state_reg == BK_MUL) begin
            prod_reg <= mul_prod;
        end
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The divider is only started while it is idle.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Jobs are only taken from a non-empty queue.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("job popped from an empty queue");

    // A loaded result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while stalled");

endmodule

// ----- hdl/adc_measure_sequencer_avg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ADC measurement sequencer with averaging
// Top level: configuration registers, front end, job queue, back end and
// divider.
// ============================================================================
// Input words arrive on s_valid/s_ready/s_data: either a millisecond tick or
// one ADC conversion. Every accepted word gives exactly one result word on
// m_valid/m_ready/m_data with the next ADC channel, the four latest scaled
// values and a flag for each value that this word updated.
// The front end updates phase, timer and accumulators in the cycle a word
// is accepted and queues a job (two entries deep). The back end handles one
// job at a time. For a tick or an accumulating sample the back end pops the
// job in its idle state and loads the output register, which drives m_valid,
// in its output state; the queue takes words while it has room. A phase end
// runs a 32x16 multiply and the shared divider, which retires one quotient
// bit per cycle for a 26-bit quotient. A voltage end divides twice, once per
// slot, and the temperature end scales the quotient by its coefficient (an
// empty accumulator skips its division). The divider therefore sets the rate.
// The configuration port writes one register per cycle with cfg_wr_en.
// A synchronous low aresetn restores the register defaults, returns to the
// voltage phase and clears all accumulators and results. When the receiver
// stalls, the output register holds its word, the queue fills, and s_ready
// drops once the queue is full.
// ============================================================================
module adc_measure_sequencer_avg #(
    parameter int TEMP_SAMPLES = adcms_pkg::TEMP_SAMPLES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  adcms_pkg::in_item_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output adcms_pkg::out_item_t              m_data,
    input  logic                              cfg_wr_en,
    input  logic [adcms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adcms_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import adcms_pkg::*;

    cfg_t       cfg_reg;
    job_t       front_job;
    job_t       q_data;
    jobq_stat_t q_stat;
    logic       q_pop;
    logic       accept;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.split_threshold <= SPLIT_THRESHOLD_RST;
            cfg_reg.voltage_coef    <= COEF_RST;
            cfg_reg.current_coef    <= COEF_RST;
            cfg_reg.temp_coef       <= COEF_RST;
            cfg_reg.window_ms       <= WINDOW_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SPLIT_THRESHOLD: cfg_reg.split_threshold <= cfg_wr_data[SAMPLE_W-1:0];
                CFG_VOLTAGE_COEF:    cfg_reg.voltage_coef    <= cfg_wr_data[COEF_W-1:0];
                CFG_CURRENT_COEF:    cfg_reg.current_coef    <= cfg_wr_data[COEF_W-1:0];
                CFG_TEMP_COEF:       cfg_reg.temp_coef       <= cfg_wr_data[COEF_W-1:0];
                CFG_WINDOW_MS:       cfg_reg.window_ms       <= cfg_wr_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input handshake: a word is taken whenever the queue has room.
    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    adcms_front #(
        .TEMP_SAMPLES (TEMP_SAMPLES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .job     (front_job)
    );

    adcms_jobq u_jobq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (accept),
        .wr_data (front_job),
        .pop     (q_pop),
        .rd_data (q_data),
        .stat    (q_stat)
    );

    adcms_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    adcms_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_data  (q_data),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .cfg     (cfg_reg),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
